// ===== hw/rtl/amfp_pkg.sv =====
// Shared constants and controller/datapath types of the measurement frame parser.
package amfp_pkg;

   localparam int DEF_FRAME_BYTES = 47;
   localparam int DEF_FIELD_CHARS = 23;
   localparam int DEF_MAX_VALUES  = 4;
   localparam int DEF_FRAC_DIGITS = 4;

   localparam int BYTE_WIDTH  = 8;
   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = 2;
   localparam int MAXV_WIDTH  = 3;

   // Configuration port.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [MAXV_WIDTH-1:0] MAXV_RESET = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_frame;
      logic take_byte;
      logic count_byte;
      logic clear_field;
      logic scale_step;
      logic store_value;
      logic emit_load;
   } amfp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_timeout;
      logic in_etx;
      logic in_field_end;
      logic need_store;
      logic scale_done;
      logic out_free;
      logic emit_last;
   } amfp_status_type;

endpackage

// ===== hw/rtl/amfp_if.sv =====
// Handshake channels for received bytes and parsed values.
interface amfp_req_if import amfp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface amfp_rsp_if import amfp_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [INDEX_WIDTH-1:0]        value_index;
   logic                          has_value;
   logic                          frame_last;

   modport source (output valid, output value, output value_index, output has_value,
                   output frame_last, input ready);
   modport sink   (input valid, input value, input value_index, input has_value,
                   input frame_last, output ready);
endinterface

// ===== hw/rtl/amfp_csr.sv =====
// Configuration register block holding the per-frame value limit.
module amfp_csr import amfp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic [MAXV_WIDTH-1:0]     max_values
);

   localparam logic [CSR_ADDR_WIDTH-3:0] REG_MAX_VALUES = '0;

   logic [MAXV_WIDTH-1:0] max_values_ff;
   logic [MAXV_WIDTH-1:0] max_values_in;
   logic                  hit;

   // Registers are decoded on the word address; byte lanes are ignored.
   assign hit = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_MAX_VALUES);

   always_comb begin
      max_values_in = max_values_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         max_values_in = csr_pwdata[MAXV_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_values_ff <= MAXV_RESET;
      end else begin
         max_values_ff <= max_values_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {{(CSR_DATA_WIDTH-MAXV_WIDTH){1'b0}}, max_values_ff} : '0;
   assign max_values = max_values_ff;

endmodule

// ===== hw/rtl/amfp_ctrl.sv =====
// Controller state machine sequencing byte intake, value scaling and result emission.
module amfp_ctrl import amfp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  amfp_status_type sts,
   output amfp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_FINISH = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       etx_ff;
   logic       etx_in;

   always_comb begin
      state_in  = state_ff;
      etx_in    = etx_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               priority if (sts.in_timeout) begin
                  cmd.clear_frame = 1'b1;
               end else if (sts.in_etx) begin
                  etx_in   = 1'b1;
                  state_in = ST_FINISH;
               end else if (sts.in_field_end) begin
                  cmd.count_byte = 1'b1;
                  etx_in         = 1'b0;
                  state_in       = ST_FINISH;
               end else begin
                  cmd.take_byte = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            // A field with a digit is scaled one decade per cycle before it is stored, if the store has room.
            if (!sts.need_store) begin
               cmd.clear_field = 1'b1;
               state_in        = etx_ff ? ST_EMIT : ST_IDLE;
            end else if (!sts.scale_done) begin
               cmd.scale_step = 1'b1;
            end else begin
               cmd.store_value = 1'b1;
               state_in        = etx_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear_frame = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         etx_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         etx_ff   <= etx_in;
      end
   end

endmodule

// ===== hw/rtl/amfp_dp.sv =====
// Datapath: frame and field state, number accumulator, value store and result register.
module amfp_dp import amfp_pkg::*; #(
   parameter int FRAME_BYTES = DEF_FRAME_BYTES,
   parameter int FIELD_CHARS = DEF_FIELD_CHARS,
   parameter int MAX_VALUES  = DEF_MAX_VALUES,
   parameter int FRAC_DIGITS = DEF_FRAC_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_action,
   input  logic [BYTE_WIDTH-1:0] in_byte,
   input  logic [MAXV_WIDTH-1:0] max_values,
   input  amfp_cmd_type          cmd,
   output amfp_status_type       sts,
   amfp_rsp_if.source            rsp_port
);

   localparam int BCW = $clog2(FRAME_BYTES + 1);
   localparam int CCW = $clog2(FIELD_CHARS + 1);
   localparam int VCW = $clog2(MAX_VALUES + 1);
   localparam int FW  = $clog2(FRAC_DIGITS + 1);
   localparam int IW  = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
   localparam int CW  = (VCW > MAXV_WIDTH) ? VCW : MAXV_WIDTH;
   localparam int ACC_WIDTH = VALUE_WIDTH - 1;
   localparam logic [ACC_WIDTH-1:0] SAT_LIMIT = '1;

   localparam logic [BYTE_WIDTH-1:0] CH_ETX   = 8'h03;
   localparam logic [BYTE_WIDTH-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CH_SEMI  = 8'h3B;
   localparam logic [BYTE_WIDTH-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CH_POINT = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'h39;

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_SIGN  = 3'd1;
   localparam logic [2:0] PH_INT   = 3'd2;
   localparam logic [2:0] PH_FRAC  = 3'd3;
   localparam logic [2:0] PH_DONE  = 3'd4;

   // Multiply by ten with shifts, add a digit, and clamp at the saturation limit.
   function automatic logic [ACC_WIDTH-1:0] mul10_add(input logic [ACC_WIDTH-1:0] a,
                                                       input logic [3:0] d);
      logic [ACC_WIDTH+3:0] p;
      p = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {{ACC_WIDTH{1'b0}}, d};
      if (p > {4'b0000, SAT_LIMIT}) begin
         return SAT_LIMIT;
      end
      return p[ACC_WIDTH-1:0];
   endfunction

   logic [BCW-1:0]       byte_cnt_ff, byte_cnt_in;
   logic                 ended_ff, ended_in;
   logic [CCW-1:0]       char_cnt_ff, char_cnt_in;
   logic [2:0]           phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic                 digit_seen_ff, digit_seen_in;
   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [FW-1:0]        frac_ff, frac_in;
   logic [VCW-1:0]       vcount_ff, vcount_in;
   logic [CW-1:0]        emit_idx_ff, emit_idx_in;

   logic signed [VALUE_WIDTH-1:0] store_ff [MAX_VALUES];
   logic signed [VALUE_WIDTH-1:0] store_word;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [INDEX_WIDTH-1:0]        rsp_index_ff;
   logic                          rsp_has_ff;
   logic                          rsp_last_ff;

   logic [BYTE_WIDTH-1:0] ch;
   logic                  is_digit, is_sign, is_point, frame_open;
   logic [CW-1:0]         limit, n_emit;
   logic                  emit_has;

   assign ch         = (in_byte == CH_COMMA) ? CH_POINT : in_byte;
   assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_sign    = (ch == CH_MINUS) || (ch == CH_PLUS);
   assign is_point   = (ch == CH_POINT);
   assign frame_open = !ended_ff && (byte_cnt_ff < BCW'(FRAME_BYTES));

   assign limit  = (CW'(max_values) >= CW'(MAX_VALUES)) ? CW'(MAX_VALUES) : CW'(max_values);
   assign n_emit = (CW'(vcount_ff) < limit) ? CW'(vcount_ff) : limit;
   assign emit_has = (n_emit != '0);

   assign sts.in_timeout   = in_action;
   assign sts.in_etx       = !in_action && (in_byte == CH_ETX);
   assign sts.in_field_end = !in_action && (in_byte == CH_SEMI) && frame_open;
   assign sts.need_store   = digit_seen_ff && (vcount_ff < VCW'(MAX_VALUES));
   assign sts.scale_done   = (frac_ff == FW'(FRAC_DIGITS));
   assign sts.out_free     = !rsp_valid_ff || rsp_port.ready;
   assign sts.emit_last    = !emit_has || (CW'(emit_idx_ff + 1'b1) == n_emit);

   always_comb begin
      byte_cnt_in   = byte_cnt_ff;
      ended_in      = ended_ff;
      char_cnt_in   = char_cnt_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      digit_seen_in = digit_seen_ff;
      acc_in        = acc_ff;
      frac_in       = frac_ff;
      vcount_in     = vcount_ff;
      emit_idx_in   = emit_idx_ff;
      priority if (cmd.clear_frame || cmd.clear_field || cmd.store_value) begin
         char_cnt_in   = '0;
         phase_in      = PH_START;
         neg_in        = 1'b0;
         digit_seen_in = 1'b0;
         acc_in        = '0;
         frac_in       = '0;
         if (cmd.clear_frame) begin
            byte_cnt_in = '0;
            ended_in    = 1'b0;
            vcount_in   = '0;
            emit_idx_in = '0;
         end else if (cmd.store_value) begin
            vcount_in = vcount_ff + 1'b1;
         end
      end else if (cmd.count_byte) begin
         byte_cnt_in = byte_cnt_ff + 1'b1;
      end else if (cmd.take_byte) begin
         if (frame_open) begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
            if (in_byte == CH_NUL) begin
               ended_in = 1'b1;
            end else if ((is_digit || is_sign || is_point) &&
                         (char_cnt_ff < CCW'(FIELD_CHARS))) begin
               char_cnt_in = char_cnt_ff + 1'b1;
               if (is_digit) begin
                  digit_seen_in = 1'b1;
               end
               unique case (phase_ff)
                  PH_START, PH_SIGN: begin
                     if (is_digit) begin
                        acc_in   = mul10_add(acc_ff, ch[3:0]);
                        phase_in = PH_INT;
                     end else if (is_point) begin
                        phase_in = PH_FRAC;
                     end else if (is_sign && (phase_ff == PH_START)) begin
                        neg_in   = (ch == CH_MINUS);
                        phase_in = PH_SIGN;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_INT: begin
                     if (is_digit) begin
                        acc_in = mul10_add(acc_ff, ch[3:0]);
                     end else if (is_point) begin
                        phase_in = PH_FRAC;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_FRAC: begin
                     if (is_digit) begin
                        // Fraction digits past the kept precision are dropped.
                        if (frac_ff < FW'(FRAC_DIGITS)) begin
                           acc_in  = mul10_add(acc_ff, ch[3:0]);
                           frac_in = frac_ff + 1'b1;
                        end
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
      end else if (cmd.scale_step) begin
         acc_in  = mul10_add(acc_ff, 4'd0);
         frac_in = frac_ff + 1'b1;
      end else if (cmd.emit_load) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff   <= '0;
         ended_ff      <= 1'b0;
         char_cnt_ff   <= '0;
         phase_ff      <= PH_START;
         neg_ff        <= 1'b0;
         digit_seen_ff <= 1'b0;
         acc_ff        <= '0;
         frac_ff       <= '0;
         vcount_ff     <= '0;
         emit_idx_ff   <= '0;
      end else begin
         byte_cnt_ff   <= byte_cnt_in;
         ended_ff      <= ended_in;
         char_cnt_ff   <= char_cnt_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         digit_seen_ff <= digit_seen_in;
         acc_ff        <= acc_in;
         frac_ff       <= frac_in;
         vcount_ff     <= vcount_in;
         emit_idx_ff   <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_value) begin
         store_ff[vcount_ff[IW-1:0]] <= neg_ff ? -$signed({1'b0, acc_ff})
                                               : $signed({1'b0, acc_ff});
      end
   end

   assign store_word = store_ff[emit_idx_ff[IW-1:0]];

   // The result register frees the controller as soon as the last word is loaded.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_value_ff <= emit_has ? store_word : '0;
         rsp_index_ff <= emit_has ? emit_idx_ff[INDEX_WIDTH-1:0] : '0;
         rsp_has_ff   <= emit_has;
         rsp_last_ff  <= sts.emit_last;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.value       = rsp_value_ff;
   assign rsp_port.value_index = rsp_index_ff;
   assign rsp_port.has_value   = rsp_has_ff;
   assign rsp_port.frame_last  = rsp_last_ff;

endmodule

// ===== hw/rtl/ascii_measurement_frame_parser_unit.sv =====
// Ordinary bytes and timeouts are taken one per cycle; a ';' that closes a field holding
// a digit goes through the scaling loop, which scales the value to FRAC_DIGITS fraction digits.
// ETX runs the same field close, then emits one word per cycle while the result side is free,
// up to min(max_values, MAX_VALUES) words (one word for an empty frame) from the EMIT state.
// A result register lets the next byte be taken while the last word waits.
// Synchronous active-high reset clears all frame state and sets max_values to 4.
module ascii_measurement_frame_parser_unit import amfp_pkg::*; #(
   parameter int FRAME_BYTES = DEF_FRAME_BYTES,
   parameter int FIELD_CHARS = DEF_FIELD_CHARS,
   parameter int MAX_VALUES  = DEF_MAX_VALUES,
   parameter int FRAC_DIGITS = DEF_FRAC_DIGITS
) (
   input  logic                      clock,
   input  logic                      reset,
   amfp_req_if.sink                  req_port,
   amfp_rsp_if.source                rsp_port,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [MAXV_WIDTH-1:0] max_values;
   amfp_cmd_type          cmd;
   amfp_status_type       sts;

   amfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_values  (max_values)
   );

   amfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   amfp_dp #(
      .FRAME_BYTES (FRAME_BYTES),
      .FIELD_CHARS (FIELD_CHARS),
      .MAX_VALUES  (MAX_VALUES),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_action  (req_port.action),
      .in_byte    (req_port.rx_byte),
      .max_values (max_values),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_port   (rsp_port)
   );

endmodule

// ===== sim/tb_ascii_measurement_frame_parser_unit.sv =====
// Self-checking testbench of the ASCII measurement frame parser against a built-in parse model.
`timescale 1ns / 1ps

module tb_ascii_measurement_frame_parser_unit import amfp_pkg::*; ();

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_WORDS = 30;
   localparam longint unsigned SAT_MAG = 64'd2147483647;

   localparam logic [CSR_ADDR_WIDTH-1:0] MAXV_ADDR = '0;

   localparam logic [7:0] ETX   = 8'h03;
   localparam logic [7:0] NUL   = 8'h00;
   localparam logic [7:0] SEMI  = ";";
   localparam logic [7:0] COMMA = ",";
   localparam logic [7:0] POINT = ".";
   localparam logic [7:0] MINUS = "-";
   localparam logic [7:0] PLUS  = "+";

   localparam logic ACT_BYTE    = 1'b0;
   localparam logic ACT_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {NUM_START, NUM_SIGN, NUM_INT, NUM_FRAC, NUM_DONE} num_phase_type;

   typedef struct packed {
      logic                          action;
      logic [7:0]                    data;
      logic                          typed;
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          has;
   } rx_word_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [INDEX_WIDTH-1:0]        index;
      logic                          has;
      logic                          last;
   } parsed_value_type;

   // Where a row carries a typed result, that single word replaces the parse model's output.
   localparam rx_word_type DIRECTED [0:24] = '{
      '{ACT_BYTE, ETX, 1'b1, 32'sd0, 1'b0},
      '{ACT_BYTE, MINUS, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "9", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, COMMA, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "9", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "9", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "9", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "9", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "9", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, ETX, 1'b1, -32'sd99999, 1'b1},
      '{ACT_BYTE, "x", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "5", 1'b0, 32'sd0, 1'b0},
      '{ACT_TIMEOUT, 8'hFF, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, ETX, 1'b1, 32'sd0, 1'b0},
      '{ACT_BYTE, "7", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, NUL, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "8", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, ETX, 1'b1, 32'sd70000, 1'b1},
      '{ACT_BYTE, "1", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, SEMI, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, PLUS, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, MINUS, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "5", 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, ETX, 1'b0, 32'sd0, 1'b0},
      '{ACT_BYTE, "0", 1'b0, 32'sd0, 1'b0}
   };

   localparam logic [MAXV_WIDTH-1:0] PHASE_MAX [0:6] = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4};

   logic clock;
   logic reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   amfp_req_if req_if ();
   amfp_rsp_if rsp_if ();

   ascii_measurement_frame_parser_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Parse model state.
   int unsigned            frame_bytes_seen;
   bit                     zero_seen;
   int unsigned            field_chars;
   num_phase_type          num_phase;
   bit                     num_neg;
   bit                     num_has_digit;
   longint unsigned        num_acc;
   int unsigned            num_frac;
   logic [VALUE_WIDTH-1:0] kept_values [DEF_MAX_VALUES];
   int unsigned            kept_count;
   logic [MAXV_WIDTH-1:0]  max_values_cfg;

   parsed_value_type expected_values [$];
   rx_word_type      tx_words [$];
   rx_word_type      cur_word;

   int  errors;
   int  effective_words;
   int  idle_cycles;
   bit  quiet;
   bit  hold_request;
   int  hold_left;
   int  stall_left;

   always #1 clock = ~clock;

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   function automatic void clear_field();
      field_chars = 0;
      num_phase = NUM_START;
      num_neg = 1'b0;
      num_has_digit = 1'b0;
      num_acc = 0;
      num_frac = 0;
   endfunction

   function automatic void clear_frame();
      frame_bytes_seen = 0;
      zero_seen = 1'b0;
      kept_count = 0;
      clear_field();
   endfunction

   function automatic void add_digit(logic [7:0] c);
      num_acc = num_acc * 10 + (c - 8'h30);
      if (num_acc > SAT_MAG) num_acc = SAT_MAG;
   endfunction

   // A field holding a digit is scaled up to the full fraction width and kept if there is room.
   function automatic void close_field();
      longint unsigned mag;
      int unsigned k;
      if (num_has_digit && kept_count < DEF_MAX_VALUES) begin
         mag = num_acc;
         for (k = num_frac; k < DEF_FRAC_DIGITS; k++) begin
            mag = mag * 10;
            if (mag > SAT_MAG) mag = SAT_MAG;
         end
         kept_values[kept_count] = num_neg ? -mag[31:0] : mag[31:0];
         kept_count++;
      end
      clear_field();
   endfunction

   function automatic void take_char(logic [7:0] c);
      bit is_digit;
      bit is_sign;
      is_digit = (c >= "0" && c <= "9");
      is_sign = (c == MINUS || c == PLUS);
      if (field_chars >= DEF_FIELD_CHARS) return;
      field_chars++;
      if (is_digit) num_has_digit = 1'b1;
      case (num_phase)
         NUM_START, NUM_SIGN: begin
            if (is_digit) begin
               add_digit(c);
               num_phase = NUM_INT;
            end else if (c == POINT) begin
               num_phase = NUM_FRAC;
            end else if (is_sign && num_phase == NUM_START) begin
               num_neg = (c == MINUS);
               num_phase = NUM_SIGN;
            end else begin
               num_phase = NUM_DONE;
            end
         end
         NUM_INT: begin
            if (is_digit) add_digit(c);
            else if (c == POINT) num_phase = NUM_FRAC;
            else num_phase = NUM_DONE;
         end
         NUM_FRAC: begin
            if (is_digit) begin
               if (num_frac < DEF_FRAC_DIGITS) begin
                  add_digit(c);
                  num_frac++;
               end
            end else begin
               num_phase = NUM_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   // Runs one accepted word through the parse model; used is low for a byte the block ignores.
   function automatic void parse_word(logic action, logic [7:0] data, output bit used);
      logic [7:0]       c;
      int unsigned      lim;
      int unsigned      n;
      int unsigned      k;
      parsed_value_type r;
      used = 1'b1;
      c = data;
      if (action == ACT_TIMEOUT) begin
         clear_frame();
         return;
      end
      if (c != ETX) begin
         if (zero_seen || frame_bytes_seen >= DEF_FRAME_BYTES) begin
            used = 1'b0;
            return;
         end
         frame_bytes_seen++;
         if (c == NUL) begin
            zero_seen = 1'b1;
         end else if (c == SEMI) begin
            close_field();
         end else begin
            if (c == COMMA) c = POINT;
            if (c == MINUS || c == PLUS || c == POINT || (c >= "0" && c <= "9")) take_char(c);
         end
         return;
      end
      close_field();
      lim = (max_values_cfg < DEF_MAX_VALUES) ? max_values_cfg : DEF_MAX_VALUES;
      n = (kept_count < lim) ? kept_count : lim;
      if (n == 0) begin
         r = '{value: '0, index: '0, has: 1'b0, last: 1'b1};
         expected_values.push_back(r);
      end
      for (k = 0; k < n; k++) begin
         r.value = kept_values[k];
         r.index = k[INDEX_WIDTH-1:0];
         r.has = 1'b1;
         r.last = (k + 1 == n);
         expected_values.push_back(r);
      end
      clear_frame();
   endfunction

   always @(posedge clock) begin
      bit               used;
      int               queued;
      parsed_value_type want;
      parsed_value_type typed_value;
      if (req_if.valid && req_if.ready && !reset) begin
         queued = expected_values.size();
         parse_word(req_if.action, req_if.rx_byte, used);
         if (cur_word.typed) begin
            while (expected_values.size() > queued) void'(expected_values.pop_back());
            typed_value = '{value: cur_word.value, index: '0, has: cur_word.has, last: 1'b1};
            expected_values.push_back(typed_value);
         end
         if (used) effective_words++;
      end
      if (rsp_if.valid && rsp_if.ready && !reset) begin
         if (expected_values.size() == 0) begin
            report_mismatch("word with none expected, value", rsp_if.value, 0);
         end else begin
            want = expected_values.pop_front();
            if (rsp_if.value !== want.value)
               report_mismatch("value", rsp_if.value, want.value);
            if (rsp_if.value_index !== want.index)
               report_mismatch("value_index", rsp_if.value_index, want.index);
            if (rsp_if.has_value !== want.has)
               report_mismatch("has_value", rsp_if.has_value, want.has);
            if (rsp_if.frame_last !== want.last)
               report_mismatch("frame_last", rsp_if.frame_last, want.last);
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
   end

   // Result side: random stalls, plus one long hold-off that lets the block back up.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_CYCLES) @(posedge clock);
      $display("ascii_measurement_frame_parser_unit test failed");
      $finish;
   end

   // Returns at the rising edge that accepts the word; valid stays high for a following word.
   task automatic send_word(rx_word_type w);
      int gap;
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_word = w;
      req_if.valid <= 1'b1;
      req_if.action <= w.action;
      req_if.rx_byte <= w.data;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_values(logic [MAXV_WIDTH-1:0] v);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MAXV_ADDR;
      csr_pwdata <= CSR_DATA_WIDTH'(v);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      max_values_cfg = v;
      idle_cycles = 0;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[MAXV_WIDTH-1:0] !== v)
         report_mismatch("max_values read back", csr_prdata[MAXV_WIDTH-1:0], v);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic void push_word(logic action, logic [7:0] b);
      rx_word_type w;
      w = '{action: action, data: b, typed: 1'b0, value: '0, has: 1'b0};
      tx_words.push_back(w);
   endfunction

   function automatic logic [7:0] digit_byte();
      return 8'(8'h30 + $urandom_range(0, 9));
   endfunction

   // Any byte the parser drops without effect on a number.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == NUL || b == ETX || b == SEMI || b == COMMA || b == POINT || b == PLUS ||
             b == MINUS || (b >= "0" && b <= "9"))
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] number_char();
      case ($urandom_range(0, 13))
         10: return PLUS;
         11: return MINUS;
         12: return POINT;
         13: return COMMA;
         default: return digit_byte();
      endcase
   endfunction

   function automatic void add_field();
      int n;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_word(ACT_BYTE, noise_byte());
      case ($urandom_range(0, 5))
         0: push_word(ACT_BYTE, MINUS);
         1: push_word(ACT_BYTE, PLUS);
         default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      repeat (n) push_word(ACT_BYTE, digit_byte());
      if ($urandom_range(0, 1) == 1) begin
         push_word(ACT_BYTE, ($urandom_range(0, 1) == 1) ? POINT : COMMA);
         repeat ($urandom_range(0, 6)) push_word(ACT_BYTE, digit_byte());
      end
      // Occasionally append one more number character: a digit, sign, point or comma.
      if ($urandom_range(0, 9) == 0) push_word(ACT_BYTE, number_char());
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_word(ACT_BYTE, noise_byte());
   endfunction

   function automatic void queue_frame();
      int kind;
      int n;
      int f;
      logic [7:0] b;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         n = $urandom_range(1, 6);
         for (f = 0; f < n; f++) begin
            add_field();
            if (f < n - 1 || $urandom_range(0, 3) == 0) push_word(ACT_BYTE, SEMI);
         end
         if ($urandom_range(0, 7) == 0) begin
            push_word(ACT_BYTE, NUL);
            add_field();
         end
         push_word(ACT_BYTE, ETX);
      end else if (kind == 6) begin
         repeat ($urandom_range(1, 60)) begin
            b = 8'($urandom_range(0, 255));
            while (b == ETX) b = 8'($urandom_range(0, 255));
            push_word(ACT_BYTE, b);
         end
         push_word(ACT_BYTE, ETX);
      end else if (kind == 7) begin
         add_field();
         push_word(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 1) push_word(ACT_BYTE, ETX);
      end else if (kind == 8) begin
         // One field of 20 to 32 number characters, often longer than the character limit.
         repeat ($urandom_range(20, 32)) push_word(ACT_BYTE, number_char());
         push_word(ACT_BYTE, ETX);
      end else begin
         // More fields than can be kept, often running past the frame byte limit.
         repeat ($urandom_range(5, 9)) begin
            add_field();
            push_word(ACT_BYTE, SEMI);
         end
         push_word(ACT_BYTE, ETX);
      end
   endfunction

   initial begin : main
      int i;
      int p;
      int start_words;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = ACT_BYTE;
      req_if.rx_byte = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cur_word = '0;
      errors = 0;
      effective_words = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      hold_left = 0;
      stall_left = 0;
      max_values_cfg = MAXV_RESET;
      clear_frame();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(DIRECTED); i++) send_word(DIRECTED[i]);
      settle();

      for (p = 0; p < $size(PHASE_MAX); p++) begin
         write_max_values(PHASE_MAX[p]);
         if (p == 1) hold_request = 1'b1;
         if (p == $size(PHASE_MAX) - 1) quiet = 1'b1;
         start_words = effective_words;
         while (effective_words - start_words < PHASE_WORDS) begin
            queue_frame();
            while (tx_words.size() != 0) send_word(tx_words.pop_front());
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("ascii_measurement_frame_parser_unit test passed");
      end else begin
         $display("ascii_measurement_frame_parser_unit test failed");
      end
      $finish;
   end

endmodule
